// ----- src/dtyp_pkg.sv -----
// shared constants, types and helper functions for the segment direction angle pipeline
`timescale 1ns / 1ps
`default_nettype none

package dtyp_pkg;

  // field widths
  localparam int COORD_BITS      = 32;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int CORDIC_STAGES   = 20;
  localparam int YAW_BITS        = ANGLE_FRAC_BITS + 9;
  localparam int PITCH_BITS      = ANGLE_FRAC_BITS + 8;

  // internal number formats
  localparam int WORK_FRAC = 32;                  // angle accumulator fraction bits
  localparam int NORM_LEN  = 31;                  // bit length after normalization
  localparam int DIFF_W    = COORD_BITS + 1;      // signed coordinate difference
  localparam int MAG_W     = COORD_BITS + 1;      // magnitude of a difference
  localparam int LEN_W     = $clog2(MAG_W + 1);   // bit length 0..MAG_W
  localparam int XY_W      = NORM_LEN + 5;        // cordic x/y with gain headroom
  localparam int Z_W       = WORK_FRAC + 9;       // degrees, sign and 8 integer bits
  localparam int KY_W      = NORM_LEN + 1;        // dy times cordic gain

  // cordic gain in Q30, rounded half up when applied
  localparam int GAIN_W  = 31;
  localparam int GAIN_SH = 30;
  localparam int PROD_W  = NORM_LEN + GAIN_W + 1;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = GAIN_W'(64'd1768195363);

  // arctangent steps: table for the coarse steps, 180/pi scaled by 2^-i beyond
  localparam int ATAN_TABLE_LEN = 11;
  localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499208;
  localparam logic [63:0] ATAN_DEG_Q32 [ATAN_TABLE_LEN] = '{
    64'd193273528320, 64'd114096026022, 64'd60285206653,
    64'd30601712202,  64'd15360239180,  64'd7687607525,
    64'd3844741810,   64'd1922488225,   64'd961258780,
    64'd480631223,    64'd240315841
  };

  // side-band carried along both cordic chains
  typedef struct packed {
    logic                        zero;     // start equals end
    logic                        hz_zero;  // dx and dz both zero
    logic                        ay_zero;  // dy zero
    logic                        dy_neg;   // dy negative
    logic [LEN_W-1:0]            diff;     // extra right shift of the horizontal leg
    logic [KY_W-1:0]             ky;       // |dy| normalized and scaled by the gain
    logic signed [YAW_BITS-1:0]  yaw;      // finished yaw angle
  } dtyp_side_t;

  // atan(2^-i) in degrees with WORK_FRAC fraction bits
  function automatic logic signed [Z_W-1:0] atan_step(input int unsigned i);
    logic [63:0] v;
    if (i < ATAN_TABLE_LEN) begin
      v = ATAN_DEG_Q32[i[3:0]];
    end else begin
      v = (DEG_PER_RAD_Q32 + (64'd1 << (i - 1))) >> i;
    end
    return Z_W'(v);
  endfunction

  // number of significant bits of a magnitude
  function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] m);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (m[b]) n = LEN_W'(b + 1);
    end
    return n;
  endfunction

  // shift a magnitude so that a value of bit length len becomes NORM_LEN bits long
  function automatic logic [NORM_LEN-1:0] norm_mag(input logic [MAG_W-1:0] m,
                                                   input logic [LEN_W-1:0] len);
    logic [MAG_W+NORM_LEN-1:0] wide;
    wide = {m, {NORM_LEN{1'b0}}} >> len;
    return wide[NORM_LEN-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/dtyp_if.sv -----
// valid/ready channel interfaces for segment input and angle output
`timescale 1ns / 1ps
`default_nettype none

interface dtyp_in_if import dtyp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [COORD_BITS-1:0] end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface dtyp_out_if import dtyp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [YAW_BITS-1:0]   yaw_deg;
  logic signed [PITCH_BITS-1:0] pitch_deg;
  logic                         zero_direction;

  modport source (output valid, yaw_deg, pitch_deg, zero_direction, input ready);
  modport sink (input valid, yaw_deg, pitch_deg, zero_direction, output ready);
endinterface

`default_nettype wire

// ----- src/dtyp_cordic.sv -----
// unrolled vectoring cordic, one micro-rotation per register stage
`timescale 1ns / 1ps
`default_nettype none

module dtyp_cordic import dtyp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  input  dtyp_side_t            side_i,
  output logic                  valid_o,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [Z_W-1:0]  z_o,
  output dtyp_side_t            side_o
);

  logic                  valid_q [CORDIC_STAGES];
  logic signed [XY_W-1:0] x_q    [CORDIC_STAGES];
  logic signed [XY_W-1:0] y_q    [CORDIC_STAGES];
  logic signed [Z_W-1:0]  z_q    [CORDIC_STAGES];
  dtyp_side_t            side_q [CORDIC_STAGES];

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    localparam logic signed [Z_W-1:0] Step = atan_step(k);

    logic                  v_in;
    logic signed [XY_W-1:0] x_in, y_in, xs, ys;
    logic signed [Z_W-1:0]  z_in;
    dtyp_side_t            s_in;

    // stage input from the port or the previous stage
    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = z_i;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
      assign s_in = side_q[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;

    // valid bit
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    // micro-rotation toward the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_in[XY_W-1]) begin
          x_q[k] <= x_in + ys;
          y_q[k] <= y_in - xs;
          z_q[k] <= z_in + Step;
        end else begin
          x_q[k] <= x_in - ys;
          y_q[k] <= y_in + xs;
          z_q[k] <= z_in - Step;
        end
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STAGES-1];
  assign x_o     = x_q[CORDIC_STAGES-1];
  assign z_o     = z_q[CORDIC_STAGES-1];
  assign side_o  = side_q[CORDIC_STAGES-1];

endmodule

`default_nettype wire

// ----- src/direction_to_yaw_pitch.sv -----
// segment direction to yaw and pitch angles: top level pipeline and output buffer
// Throughput: one segment per cycle while the skid entry is empty, set by the two unrolled cordic chains.
// The output register plus one skid entry keep input ready registered and let
// new segments enter while a result waits to be taken.
// Reset clears all valid bits and the output buffer; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module direction_to_yaw_pitch import dtyp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dtyp_in_if.sink     seg_i,
  dtyp_out_if.source  ang_o
);

  localparam int RoundSh = WORK_FRAC - ANGLE_FRAC_BITS;
  localparam int RndW    = Z_W - RoundSh;
  localparam logic signed [Z_W-1:0]  RoundHalf = Z_W'(64'd1 << (RoundSh - 1));
  localparam logic signed [Z_W-1:0]  Rot90     = Z_W'(64'd90 << WORK_FRAC);
  localparam logic signed [RndW-1:0] YawLim    = RndW'(64'd180 << ANGLE_FRAC_BITS);
  localparam logic signed [RndW-1:0] PitchLim  = RndW'(64'd90 << ANGLE_FRAC_BITS);
  localparam logic signed [PITCH_BITS-1:0] PitchRight = PITCH_BITS'(PitchLim);
  localparam logic [PROD_W-1:0] GainHalf = PROD_W'(64'd1 << (GAIN_SH - 1));

  typedef struct packed {
    logic signed [YAW_BITS-1:0]   yaw;
    logic signed [PITCH_BITS-1:0] pitch;
    logic                         zero;
  } res_t;

  // round a work angle to output precision
  function automatic logic signed [RndW-1:0] round_z(input logic signed [Z_W-1:0] z);
    logic signed [Z_W-1:0] t;
    t = z + RoundHalf;
    return t[Z_W-1:RoundSh];
  endfunction

  // pipeline enable and input handshake
  logic en;
  logic skid_full_q;

  assign en          = ~skid_full_q;
  assign seg_i.ready = en;

  // stage a: coordinate differences
  logic                     a_valid_q;
  logic signed [DIFF_W-1:0] a_dx_q, a_dy_q, a_dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= seg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_dx_q <= {seg_i.end_x[COORD_BITS-1], seg_i.end_x}
              - {seg_i.start_x[COORD_BITS-1], seg_i.start_x};
      a_dy_q <= {seg_i.end_y[COORD_BITS-1], seg_i.end_y}
              - {seg_i.start_y[COORD_BITS-1], seg_i.start_y};
      a_dz_q <= {seg_i.end_z[COORD_BITS-1], seg_i.end_z}
              - {seg_i.start_z[COORD_BITS-1], seg_i.start_z};
    end
  end

  // stage b: magnitudes and signs
  logic             b_valid_q;
  logic [MAG_W-1:0] b_ax_q, b_ay_q, b_az_q;
  logic             b_sx_q, b_sy_q, b_sz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ax_q <= a_dx_q[DIFF_W-1] ? MAG_W'(-a_dx_q) : MAG_W'(a_dx_q);
      b_ay_q <= a_dy_q[DIFF_W-1] ? MAG_W'(-a_dy_q) : MAG_W'(a_dy_q);
      b_az_q <= a_dz_q[DIFF_W-1] ? MAG_W'(-a_dz_q) : MAG_W'(a_dz_q);
      b_sx_q <= a_dx_q[DIFF_W-1];
      b_sy_q <= a_dy_q[DIFF_W-1];
      b_sz_q <= a_dz_q[DIFF_W-1];
    end
  end

  // stage c: bit lengths of each magnitude
  logic             c_valid_q;
  logic [MAG_W-1:0] c_ax_q, c_ay_q, c_az_q;
  logic             c_sx_q, c_sy_q, c_sz_q;
  logic [LEN_W-1:0] c_lx_q, c_ly_q, c_lz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_ax_q <= b_ax_q;
      c_ay_q <= b_ay_q;
      c_az_q <= b_az_q;
      c_sx_q <= b_sx_q;
      c_sy_q <= b_sy_q;
      c_sz_q <= b_sz_q;
      c_lx_q <= bit_len(b_ax_q);
      c_ly_q <= bit_len(b_ay_q);
      c_lz_q <= bit_len(b_az_q);
    end
  end

  // stage d: common normalization of each cordic's operands
  logic [LEN_W-1:0] c_l1, c_l;

  assign c_l1 = (c_lx_q > c_lz_q) ? c_lx_q : c_lz_q;
  assign c_l  = (c_ly_q > c_l1) ? c_ly_q : c_l1;

  logic                d_valid_q;
  logic [NORM_LEN-1:0] d_nx_q, d_ny_q, d_nz_q;
  logic                d_sx_q, d_sy_q, d_sz_q;
  logic                d_hz_zero_q, d_ay_zero_q;
  logic [LEN_W-1:0]    d_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_nx_q      <= norm_mag(c_ax_q, c_l1);
      d_nz_q      <= norm_mag(c_az_q, c_l1);
      d_ny_q      <= norm_mag(c_ay_q, c_l);
      d_sx_q      <= c_sx_q;
      d_sy_q      <= c_sy_q;
      d_sz_q      <= c_sz_q;
      d_hz_zero_q <= (c_l1 == '0);
      d_ay_zero_q <= (c_ly_q == '0);
      d_diff_q    <= c_l - c_l1;
    end
  end

  // stage e: quadrant turn for the yaw vector, gain scaling of dy
  logic                   nx_neg, nz_neg;
  logic signed [XY_W-1:0] nx_pos, nz_pos, nz_sgn;
  logic signed [XY_W-1:0] e_x, e_y;
  logic signed [Z_W-1:0]  e_z;
  logic [PROD_W-1:0]      ky_prod;
  dtyp_side_t             e_side;

  always_comb begin
    nx_neg = d_sx_q & (|d_nx_q);
    nz_neg = d_sz_q & (|d_nz_q);
    nx_pos = XY_W'(d_nx_q);
    nz_pos = XY_W'(d_nz_q);
    nz_sgn = nz_neg ? -nz_pos : nz_pos;
    if (nx_neg && !nz_neg) begin
      e_x = nz_pos;
      e_y = nx_pos;
      e_z = Rot90;
    end else if (nx_neg) begin
      e_x = nz_pos;
      e_y = -nx_pos;
      e_z = -Rot90;
    end else begin
      e_x = nx_pos;
      e_y = nz_sgn;
      e_z = '0;
    end
    ky_prod = PROD_W'(d_ny_q) * PROD_W'(GAIN_Q30) + GainHalf;
    e_side.zero    = d_hz_zero_q & d_ay_zero_q;
    e_side.hz_zero = d_hz_zero_q;
    e_side.ay_zero = d_ay_zero_q;
    e_side.dy_neg  = d_sy_q;
    e_side.diff    = d_diff_q;
    e_side.ky      = ky_prod[GAIN_SH +: KY_W];
    e_side.yaw     = '0;
  end

  logic                   e_valid_q;
  logic signed [XY_W-1:0] e_x_q, e_y_q;
  logic signed [Z_W-1:0]  e_z_q;
  dtyp_side_t             e_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_x_q    <= e_x;
      e_y_q    <= e_y;
      e_z_q    <= e_z;
      e_side_q <= e_side;
    end
  end

  // yaw cordic
  logic                   y_valid;
  logic signed [XY_W-1:0] y_x;
  logic signed [Z_W-1:0]  y_z;
  dtyp_side_t             y_side;

  dtyp_cordic u_yaw_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (e_valid_q),
    .x_i     (e_x_q),
    .y_i     (e_y_q),
    .z_i     (e_z_q),
    .side_i  (e_side_q),
    .valid_o (y_valid),
    .x_o     (y_x),
    .z_o     (y_z),
    .side_o  (y_side)
  );

  // stage f: finish yaw, set up the pitch vector from the horizontal length
  logic signed [RndW-1:0]     yaw_rnd;
  logic signed [YAW_BITS-1:0] yaw_fin;
  logic [KY_W-1:0]            f_ky;
  logic signed [XY_W-1:0]     f_x, f_y;
  dtyp_side_t                 f_side;

  always_comb begin
    yaw_rnd = round_z(y_z);
    if (y_side.hz_zero) begin
      yaw_fin = '0;
    end else if (yaw_rnd > YawLim) begin
      yaw_fin = YAW_BITS'(YawLim);
    end else if (yaw_rnd < -YawLim) begin
      yaw_fin = YAW_BITS'(-YawLim);
    end else begin
      yaw_fin = YAW_BITS'(yaw_rnd);
    end
    f_ky       = y_side.ky;
    f_x        = XY_W'($unsigned(y_x) >> y_side.diff);
    f_y        = y_side.dy_neg ? -XY_W'(f_ky) : XY_W'(f_ky);
    f_side     = y_side;
    f_side.yaw = yaw_fin;
  end

  logic                   f_valid_q;
  logic signed [XY_W-1:0] f_x_q, f_y_q;
  dtyp_side_t             f_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= y_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_x_q    <= f_x;
      f_y_q    <= f_y;
      f_side_q <= f_side;
    end
  end

  // pitch cordic
  logic                  p_valid;
  logic signed [Z_W-1:0] p_z;
  dtyp_side_t            p_side;

  dtyp_cordic u_pitch_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid_q),
    .x_i     (f_x_q),
    .y_i     (f_y_q),
    .z_i     ('0),
    .side_i  (f_side_q),
    .valid_o (p_valid),
    .x_o     (),
    .z_o     (p_z),
    .side_o  (p_side)
  );

  // finish pitch and assemble the result
  logic signed [RndW-1:0] pitch_rnd;
  res_t                   res;

  always_comb begin
    pitch_rnd = round_z(p_z);
    if (p_side.ay_zero) begin
      res.pitch = '0;
    end else if (p_side.hz_zero) begin
      res.pitch = p_side.dy_neg ? -PitchRight : PitchRight;
    end else if (pitch_rnd > PitchLim) begin
      res.pitch = PITCH_BITS'(PitchLim);
    end else if (pitch_rnd < -PitchLim) begin
      res.pitch = PITCH_BITS'(-PitchLim);
    end else begin
      res.pitch = PITCH_BITS'(pitch_rnd);
    end
    res.yaw  = p_side.yaw;
    res.zero = p_side.zero;
  end

  // output register with one skid entry
  logic push, pop;
  logic out_valid_q;
  res_t out_q, skid_q;

  assign push = p_valid & en;
  assign pop  = out_valid_q & ang_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (skid_full_q) begin
      if (pop) skid_full_q <= 1'b0;
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_full_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_full_q) begin
      if (pop) out_q <= skid_q;
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign ang_o.valid          = out_valid_q;
  assign ang_o.yaw_deg        = out_q.yaw;
  assign ang_o.pitch_deg      = out_q.pitch;
  assign ang_o.zero_direction = out_q.zero;

  // a full skid entry always sits behind a held output
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_full_q |-> out_valid_q)
    else $error("skid entry full while output register empty");

  // taking the output frees the skid entry on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q && ang_o.ready |=> !skid_full_q)
    else $error("skid entry not released after output transfer");

  // a zero-length segment gives zero angles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.zero |-> (out_q.yaw == '0) && (out_q.pitch == '0))
    else $error("nonzero angle on zero-length segment");

  // angles stay inside their clamp limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.yaw <= YawLim) && (out_q.yaw >= -YawLim)
                 && (out_q.pitch <= PitchLim) && (out_q.pitch >= -PitchLim))
    else $error("angle outside clamp range");

endmodule

`default_nettype wire
